FILE: hdl/otsu_pkg.sv
// Shared types and constants for the Otsu threshold block.
// Holds the FSM enums and the request/response structs of the limb multiplier.
// No dependencies.
package otsu_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned PP_W    = 2 * LIMB_W;
  localparam int unsigned A_LIMBS = 4;
  localparam int unsigned B_LIMBS = 2;
  localparam int unsigned AL_W    = 2;
  localparam int unsigned BL_W    = 1;
  localparam int unsigned MC_W    = AL_W + BL_W;
  localparam int unsigned SH_W    = 3;
  localparam int unsigned MA_W    = A_LIMBS * LIMB_W;
  localparam int unsigned MB_W    = B_LIMBS * LIMB_W;
  localparam int unsigned MP_W    = MA_W + MB_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_RD,
    ST_ACC,
    ST_GO,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    JOB_P,
    JOB_Q,
    JOB_DEN,
    JOB_SQ,
    JOB_LHS,
    JOB_RHS
  } job_e;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MP_W-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: hdl/otsu_mul.sv
// Multi-cycle wide multiplier: one 32x32 limb product per cycle, shifted and accumulated.
// 128-bit by 64-bit operands, 192-bit product. Depends on otsu_pkg.
module otsu_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otsu_pkg::mul_req_t req_i,
  output otsu_pkg::mul_rsp_t rsp_o
);

  logic [otsu_pkg::MA_W-1:0]   a_q;
  logic [otsu_pkg::MB_W-1:0]   b_q;
  logic [otsu_pkg::MC_W-1:0]   cnt_q;
  logic                        run_q;
  logic                        pp_vld_q;
  logic                        pp_last_q;
  logic                        done_q;
  logic [otsu_pkg::PP_W-1:0]   pp_q;
  logic [otsu_pkg::PP_W-1:0]   pp_d;
  logic [otsu_pkg::SH_W-1:0]   sh_q;
  logic [otsu_pkg::MP_W-1:0]   acc_q;
  logic [otsu_pkg::AL_W-1:0]   ai;
  logic [otsu_pkg::BL_W-1:0]   bi;
  logic [otsu_pkg::LIMB_W-1:0] a_limb;
  logic [otsu_pkg::LIMB_W-1:0] b_limb;
  logic                        cnt_last;

  assign bi       = cnt_q[otsu_pkg::BL_W-1:0];
  assign ai       = cnt_q[otsu_pkg::BL_W +: otsu_pkg::AL_W];
  assign a_limb   = a_q[ai*otsu_pkg::LIMB_W +: otsu_pkg::LIMB_W];
  assign b_limb   = b_q[bi*otsu_pkg::LIMB_W +: otsu_pkg::LIMB_W];
  assign pp_d     = a_limb * b_limb;
  assign cnt_last = cnt_q == otsu_pkg::MC_W'(otsu_pkg::A_LIMBS * otsu_pkg::B_LIMBS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      cnt_q     <= '0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_vld_q  <= run_q;
      pp_last_q <= run_q && cnt_last;
      done_q    <= pp_vld_q && pp_last_q;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + otsu_pkg::MC_W'(1);
        if (cnt_last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + (otsu_pkg::MP_W'(pp_q) << (otsu_pkg::LIMB_W * sh_q));
    end
    if (run_q) begin
      pp_q <= pp_d;
      sh_q <= otsu_pkg::SH_W'(ai) + otsu_pkg::SH_W'(bi);
    end
  end

  assign rsp_o.busy = run_q | pp_vld_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

FILE: hdl/otsu_threshold_from_histogram_top.sv
// Otsu threshold from a grey-level histogram: top level with histogram RAM and scan sequencer.
// Depends on otsu_pkg and otsu_mul.
//
// Pixels are taken one per cycle while idle; each goes through a read-modify-write of the
// histogram RAM (registered read, forwarding of the previous write), so back-to-back pixels
// of the same level are counted correctly. Pixel count and intensity sum are kept in registers
// and stop at MAX_PIXELS. After reset a clearing pass zeroes every bin before the first
// pixel is taken. The last pixel starts the scan: a drain state, then a read and an accumulate
// state per bin; a bin that splits the image into two nonempty classes also runs six exact
// products through the shared 32x32 limb multiplier. The bins are zeroed as they are read.
// The threshold then goes to the output register, and pixels are taken again once it is
// loaded; the next scan waits if the previous result has not been transferred.
module otsu_threshold_from_histogram_top #(
  parameter int unsigned LEVELS     = 256,
  parameter int unsigned MAX_PIXELS = 1048576
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [otsu_pkg::PIX_W-1:0] pixel_i,
  input  logic                       last_pixel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [otsu_pkg::PIX_W-1:0] threshold_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned IW = $clog2(longint'(LEVELS - 1) * longint'(MAX_PIXELS) + 1);
  localparam int unsigned DW = IW + CW;
  localparam int unsigned NW = 2 * CW;
  localparam int unsigned QW = 2 * DW;
  localparam int unsigned SW = QW + NW;

  otsu_pkg::state_e state_q, state_d;
  otsu_pkg::job_e   job_q, job_d;
  otsu_pkg::mul_req_t mreq;
  otsu_pkg::mul_rsp_t mrsp;
  logic [otsu_pkg::MA_W-1:0] mul_a;
  logic [otsu_pkg::MB_W-1:0] mul_b;

  logic [CW-1:0] hist_mem [LEVELS];
  logic          mem_we;
  logic          mem_re;
  logic [LW-1:0] mem_wa;
  logic [LW-1:0] mem_ra;
  logic [CW-1:0] mem_wd;
  logic [CW-1:0] rd_q;

  logic [LW-1:0] t_q;
  logic [LW-1:0] t_next;
  logic          last_bin;
  logic          bin_step;
  logic [CW-1:0] pix_tot_q;
  logic [IW-1:0] int_tot_q;

  logic          in_xfer;
  logic          count_en;
  logic [LW-1:0] px_idx;
  logic          s1_vld_q;
  logic [LW-1:0] s1_addr_q;
  logic [CW-1:0] s1_new;
  logic          fwd_vld_q;
  logic [LW-1:0] fwd_addr_q;
  logic [CW-1:0] fwd_data_q;

  logic [CW-1:0] wb_q;
  logic [CW-1:0] wf_q;
  logic [IW-1:0] sb_q;
  logic [CW-1:0] wb_new;
  logic [CW-1:0] wf_new;
  logic          eval_bin;
  logic [DW-1:0] p_q;
  logic [DW-1:0] q_q;
  logic [DW-1:0] d_abs;
  logic [NW-1:0] den_q;
  logic [QW-1:0] sq_q;
  logic [SW-1:0] lhs_q;
  logic [QW-1:0] best_sq_q;
  logic [NW-1:0] best_den_q;
  logic [LW-1:0] best_t_q;
  logic          lhs_win;

  logic                       out_valid_q;
  logic [otsu_pkg::PIX_W-1:0] thr_q;
  logic                       out_free;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign count_en = in_xfer && (pix_tot_q < CW'(MAX_PIXELS));
  assign px_idx   = (32'(pixel_i) >= LEVELS) ? LW'(LEVELS - 1) : LW'(pixel_i);
  assign s1_new   = ((fwd_vld_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rd_q) + CW'(1);

  assign last_bin = t_q == LW'(LEVELS - 1);
  assign t_next   = last_bin ? '0 : t_q + LW'(1);
  assign wb_new   = wb_q + rd_q;
  assign wf_new   = pix_tot_q - wb_new;
  assign eval_bin = (wf_q != '0) && (wb_new != '0) && (wf_new != '0);
  assign d_abs    = (p_q >= q_q) ? (p_q - q_q) : (q_q - p_q);
  assign lhs_win  = lhs_q > mrsp.prod[SW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  otsu_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  // next state, RAM port control, multiplier request
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    in_ready_o = 1'b0;
    bin_step   = 1'b0;
    mem_we     = s1_vld_q;
    mem_wa     = s1_addr_q;
    mem_wd     = s1_new;
    mem_re     = 1'b0;
    mem_ra     = t_q;
    mreq.start = 1'b0;
    mreq.a     = mul_a;
    mreq.b     = mul_b;
    unique case (state_q)
      otsu_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = t_q;
        mem_wd   = '0;
        bin_step = 1'b1;
        if (last_bin) begin
          state_d = otsu_pkg::ST_IDLE;
        end
      end
      otsu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (count_en) begin
          mem_re = 1'b1;
          mem_ra = px_idx;
        end
        if (in_xfer && last_pixel_i) begin
          state_d = otsu_pkg::ST_DRAIN;
        end
      end
      otsu_pkg::ST_DRAIN: begin
        state_d = otsu_pkg::ST_RD;
      end
      otsu_pkg::ST_RD: begin
        mem_re  = 1'b1;
        mem_ra  = t_q;
        mem_we  = 1'b1;
        mem_wa  = t_q;
        mem_wd  = '0;
        state_d = otsu_pkg::ST_ACC;
      end
      otsu_pkg::ST_ACC: begin
        if (eval_bin) begin
          state_d = otsu_pkg::ST_GO;
          job_d   = otsu_pkg::JOB_P;
        end else begin
          bin_step = 1'b1;
          state_d  = last_bin ? otsu_pkg::ST_DONE : otsu_pkg::ST_RD;
        end
      end
      otsu_pkg::ST_GO: begin
        mreq.start = 1'b1;
        state_d    = otsu_pkg::ST_WAIT;
      end
      otsu_pkg::ST_WAIT: begin
        if (mrsp.done) begin
          if (job_q == otsu_pkg::JOB_RHS) begin
            bin_step = 1'b1;
            state_d  = last_bin ? otsu_pkg::ST_DONE : otsu_pkg::ST_RD;
          end else begin
            state_d = otsu_pkg::ST_GO;
            unique case (job_q)
              otsu_pkg::JOB_P:   job_d = otsu_pkg::JOB_Q;
              otsu_pkg::JOB_Q:   job_d = otsu_pkg::JOB_DEN;
              otsu_pkg::JOB_DEN: job_d = otsu_pkg::JOB_SQ;
              otsu_pkg::JOB_SQ:  job_d = otsu_pkg::JOB_LHS;
              default:           job_d = otsu_pkg::JOB_RHS;
            endcase
          end
        end
      end
      otsu_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = otsu_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // multiplier operands per job
  always_comb begin
    unique case (job_q)
      otsu_pkg::JOB_P: begin
        mul_a = otsu_pkg::MA_W'(sb_q);
        mul_b = otsu_pkg::MB_W'(pix_tot_q);
      end
      otsu_pkg::JOB_Q: begin
        mul_a = otsu_pkg::MA_W'(int_tot_q);
        mul_b = otsu_pkg::MB_W'(wb_q);
      end
      otsu_pkg::JOB_DEN: begin
        mul_a = otsu_pkg::MA_W'(wb_q);
        mul_b = otsu_pkg::MB_W'(wf_q);
      end
      otsu_pkg::JOB_SQ: begin
        mul_a = otsu_pkg::MA_W'(d_abs);
        mul_b = otsu_pkg::MB_W'(d_abs);
      end
      otsu_pkg::JOB_LHS: begin
        mul_a = otsu_pkg::MA_W'(sq_q);
        mul_b = otsu_pkg::MB_W'(best_den_q);
      end
      otsu_pkg::JOB_RHS: begin
        mul_a = otsu_pkg::MA_W'(best_sq_q);
        mul_b = otsu_pkg::MB_W'(den_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= hist_mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= otsu_pkg::ST_CLEAR;
      job_q       <= otsu_pkg::JOB_P;
      t_q         <= '0;
      pix_tot_q   <= '0;
      int_tot_q   <= '0;
      s1_vld_q    <= 1'b0;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      s1_vld_q  <= count_en;
      fwd_vld_q <= s1_vld_q;
      if (bin_step) begin
        t_q <= t_next;
      end
      if (state_q == otsu_pkg::ST_DONE && out_free) begin
        pix_tot_q   <= '0;
        int_tot_q   <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (count_en) begin
          pix_tot_q <= pix_tot_q + CW'(1);
          int_tot_q <= int_tot_q + IW'(px_idx);
        end
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // histogram pipeline and scan datapath
  always_ff @(posedge clk_i) begin
    s1_addr_q  <= px_idx;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= s1_new;
    if (state_q == otsu_pkg::ST_DONE && out_free) begin
      thr_q <= otsu_pkg::PIX_W'(best_t_q);
    end
    if (state_q == otsu_pkg::ST_DRAIN) begin
      wb_q       <= '0;
      wf_q       <= pix_tot_q;
      sb_q       <= '0;
      best_sq_q  <= '0;
      best_den_q <= NW'(1);
      best_t_q   <= '0;
    end
    if (state_q == otsu_pkg::ST_ACC && wf_q != '0) begin
      wb_q <= wb_new;
      if (wb_new != '0) begin
        wf_q <= wf_new;
        if (wf_new != '0) begin
          sb_q <= sb_q + IW'(t_q) * IW'(rd_q);
        end
      end
    end
    if (state_q == otsu_pkg::ST_WAIT && mrsp.done) begin
      unique case (job_q)
        otsu_pkg::JOB_P:   p_q   <= mrsp.prod[DW-1:0];
        otsu_pkg::JOB_Q:   q_q   <= mrsp.prod[DW-1:0];
        otsu_pkg::JOB_DEN: den_q <= mrsp.prod[NW-1:0];
        otsu_pkg::JOB_SQ:  sq_q  <= mrsp.prod[QW-1:0];
        otsu_pkg::JOB_LHS: lhs_q <= mrsp.prod[SW-1:0];
        otsu_pkg::JOB_RHS: begin
          if (lhs_win) begin
            best_sq_q  <= sq_q;
            best_den_q <= den_q;
            best_t_q   <= t_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign threshold_o = thr_q;

  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> !mrsp.busy)
    else $error("multiplier started while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_tot_q <= CW'(MAX_PIXELS))
    else $error("pixel count above limit");

  a_class_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == otsu_pkg::ST_RD || state_q == otsu_pkg::ST_ACC ||
     state_q == otsu_pkg::ST_GO || state_q == otsu_pkg::ST_WAIT)
    |-> ((CW + 1)'(wb_q) + (CW + 1)'(wf_q)) == (CW + 1)'(pix_tot_q))
    else $error("class weights do not add up to pixel count");

  a_s1_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(in_valid_i && in_ready_o))
    else $error("histogram update without input transfer");

endmodule
